// File: rtl/kvmp_pkg.sv
package kvmp_pkg;

    localparam int KeyCount = 3;
    localparam int ValueWidthDefault = 64;

    localparam int KEY_SNAPSHOT = 0;
    localparam int KEY_SEQUENCE = 1;
    localparam int KEY_SESSION  = 2;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_MALFORMED  = 2'd1,
        STATUS_INCOMPLETE = 2'd2
    } kvmp_status_t;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [15:0][7:0] KEY_TEXT_SNAPSHOT = {"snapshot", "_id", 40'd0};
    localparam logic [15:0][7:0] KEY_TEXT_SEQUENCE = {"sequence", 64'd0};
    localparam logic [15:0][7:0] KEY_TEXT_SESSION  = {"session", 72'd0};

    localparam logic [3:0] KEY_LEN [KeyCount] = '{4'd11, 4'd8, 4'd7};

    function automatic logic [7:0] key_char(input logic [1:0] key, input logic [3:0] pos);
        logic [3:0] idx;
        logic [7:0] ch;
        idx = 4'd15 - pos;
        unique case (key)
            2'(KEY_SNAPSHOT): ch = KEY_TEXT_SNAPSHOT[idx];
            2'(KEY_SEQUENCE): ch = KEY_TEXT_SEQUENCE[idx];
            2'(KEY_SESSION):  ch = KEY_TEXT_SESSION[idx];
            default:          ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/key_value_manifest_parser_top.sv
// Parses a key=value manifest arriving one byte per transaction on the s_ channel
// (s_tlast marks end of text; its s_tdata is ignored) and returns one result per
// manifest on the m_ channel. Lines end at LF, one CR before LF or end of text is
// dropped, empty lines are skipped; the snapshot, sequence and session keys take
// decimal values up to 2^VALUE_WIDTH-1. One byte is taken every clock but for the
// stall below: a transaction is held in the input register, and at the edge that
// retires it the key compare and multiply-by-ten accumulate update the line state,
// so a result is loaded into the output register at the edge that retires its
// end-of-text transaction from the input register. Input stalls only when an
// end-of-text transaction finds an untaken result still in the output register.
module key_value_manifest_parser_top #(
    parameter int VALUE_WIDTH = kvmp_pkg::ValueWidthDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // end_of_input
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // [63:0] snapshot_value, [127:64] sequence_value,
                                    // [191:128] session_value, [192] session_given,
                                    // [194:193] missing_mask, [199:195] zero
    output logic [1:0]   m_tuser    // [1:0] status
);
    import kvmp_pkg::*;

    typedef struct packed {
        logic [KeyCount-1:0]    cand;
        logic [3:0]             klen;
        logic                   in_value;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   has_digit;
        logic                   bad;
        logic                   nonempty;
    } line_t;

    localparam line_t LINE_RESET = '{
        cand: '1, klen: '0, in_value: 1'b0, acc: '0,
        has_digit: 1'b0, bad: 1'b0, nonempty: 1'b0
    };

    function automatic line_t cr_step(input line_t ln);
        line_t r;
        r = ln;
        r.nonempty = 1'b1;
        if (ln.in_value) begin
            r.bad = 1'b1;
        end else begin
            r.cand = '0;
            if (ln.klen != 4'd15) r.klen = ln.klen + 4'd1;
        end
        return r;
    endfunction

    function automatic line_t byte_step(input line_t ln, input logic [7:0] c);
        line_t r;
        logic [VALUE_WIDTH+3:0] wide;
        logic [VALUE_WIDTH+3:0] prod;
        r = ln;
        r.nonempty = 1'b1;
        wide = {4'd0, ln.acc};
        prod = (wide << 3) + (wide << 1) + (VALUE_WIDTH+4)'(c[3:0]);
        if (ln.in_value) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (|prod[VALUE_WIDTH+3:VALUE_WIDTH]) r.bad = 1'b1;
                else r.acc = prod[VALUE_WIDTH-1:0];
                r.has_digit = 1'b1;
            end else begin
                r.bad = 1'b1;
            end
        end else if (c == CHAR_EQUAL) begin
            r.in_value = 1'b1;
        end else begin
            for (int k = 0; k < KeyCount; k++) begin
                if (ln.klen >= KEY_LEN[k] || key_char(2'(k), ln.klen) != c) r.cand[k] = 1'b0;
            end
            if (ln.klen != 4'd15) r.klen = ln.klen + 4'd1;
        end
        return r;
    endfunction

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;

    line_t                  line_reg, line_next;
    logic                   pcr_reg, pcr_next;
    logic                   err_reg, err_next;
    logic [KeyCount-1:0]    fields_reg, fields_next;
    logic [VALUE_WIDTH-1:0] snap_reg, snap_next;
    logic [VALUE_WIDTH-1:0] seq_reg, seq_next;
    logic [VALUE_WIDTH-1:0] sess_reg, sess_next;

    logic                   m_valid_reg;
    kvmp_status_t           m_status_reg, m_status_next;
    logic [63:0]            m_snap_reg, m_snap_next;
    logic [63:0]            m_seq_reg, m_seq_next;
    logic [63:0]            m_sess_reg, m_sess_next;
    logic                   m_given_reg, m_given_next;
    logic [1:0]             m_missing_reg, m_missing_next;

    logic out_free;
    logic take;

    assign out_free = !m_valid_reg || m_tready;
    assign take     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || take;

    always_comb begin
        line_t               ln;
        logic                do_finish;
        logic [KeyCount-1:0] hit;
        logic                good;
        logic [1:0]          missing;

        ln          = line_reg;
        do_finish   = 1'b0;
        pcr_next    = pcr_reg;
        err_next    = err_reg;
        fields_next = fields_reg;
        snap_next   = snap_reg;
        seq_next    = seq_reg;
        sess_next   = sess_reg;

        if (in_last_reg) begin
            pcr_next  = 1'b0;
            do_finish = 1'b1;
        end else if (!err_reg) begin
            if (pcr_reg && in_byte_reg == CHAR_LF) begin
                pcr_next  = 1'b0;
                do_finish = 1'b1;
            end else begin
                if (pcr_reg) ln = cr_step(ln);
                pcr_next = (in_byte_reg == CHAR_CR);
                if (in_byte_reg == CHAR_LF) do_finish = 1'b1;
                else if (in_byte_reg != CHAR_CR) ln = byte_step(ln, in_byte_reg);
            end
        end

        for (int k = 0; k < KeyCount; k++) begin
            hit[k] = ln.cand[k] && (ln.klen == KEY_LEN[k]);
        end
        good = ln.in_value && ln.has_digit && !ln.bad && (|hit) && !(|(hit & fields_reg));

        if (do_finish) begin
            if (!err_reg && ln.nonempty) begin
                if (!good) begin
                    err_next = 1'b1;
                end else begin
                    fields_next = fields_reg | hit;
                    if (hit[KEY_SNAPSHOT]) snap_next = ln.acc;
                    if (hit[KEY_SEQUENCE]) seq_next  = ln.acc;
                    if (hit[KEY_SESSION])  sess_next = ln.acc;
                end
            end
            ln = LINE_RESET;
        end
        line_next = ln;

        missing        = ~fields_next[KEY_SEQUENCE:KEY_SNAPSHOT];
        m_status_next  = STATUS_OK;
        m_snap_next    = '0;
        m_seq_next     = '0;
        m_sess_next    = '0;
        m_given_next   = 1'b0;
        m_missing_next = '0;
        if (err_next) begin
            m_status_next = STATUS_MALFORMED;
        end else if (|missing) begin
            m_status_next  = STATUS_INCOMPLETE;
            m_missing_next = missing;
        end else begin
            m_snap_next  = 64'(snap_next);
            m_seq_next   = 64'(seq_next);
            m_sess_next  = 64'(sess_next);
            m_given_next = fields_next[KEY_SESSION];
        end

        if (in_last_reg) begin
            err_next    = 1'b0;
            fields_next = '0;
            snap_next   = '0;
            seq_next    = '0;
            sess_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            line_reg     <= LINE_RESET;
            pcr_reg      <= 1'b0;
            err_reg      <= 1'b0;
            fields_reg   <= '0;
            snap_reg     <= '0;
            seq_reg      <= '0;
            sess_reg     <= '0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (take) begin
                line_reg   <= line_next;
                pcr_reg    <= pcr_next;
                err_reg    <= err_next;
                fields_reg <= fields_next;
                snap_reg   <= snap_next;
                seq_reg    <= seq_next;
                sess_reg   <= sess_next;
            end
            if (take && in_last_reg) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (take && in_last_reg) begin
            m_status_reg  <= m_status_next;
            m_snap_reg    <= m_snap_next;
            m_seq_reg     <= m_seq_next;
            m_sess_reg    <= m_sess_next;
            m_given_reg   <= m_given_next;
            m_missing_reg <= m_missing_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'd0, m_missing_reg, m_given_reg, m_sess_reg, m_seq_reg, m_snap_reg};

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(take && in_last_reg))
        else $error("result without end of text");

    a_incomplete_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == STATUS_INCOMPLETE |-> m_missing_reg != 2'd0 && !m_given_reg)
        else $error("incomplete result carries bad fields");

    a_manifest_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_last_reg |=> fields_reg == '0 && !err_reg && !pcr_reg)
        else $error("state not cleared after end of text");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg && !(take && in_last_reg) |=> err_reg)
        else $error("latched error lost");

endmodule

// File: verif/manifest_result_checker.sv
`timescale 1ns / 100ps

module manifest_result_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // end_of_input
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [199:0] m_tdata,   // [63:0] snapshot_value, [127:64] sequence_value,
                                    // [191:128] session_value, [192] session_given,
                                    // [194:193] missing_mask, [199:195] zero
    input  logic [1:0]   m_tuser,   // [1:0] status
    output int           mismatch_count,
    output int           pending_results,
    output int           results_checked
);
    import kvmp_pkg::*;

    typedef struct packed {
        kvmp_status_t status;
        logic [63:0]  snap_value;
        logic [63:0]  seq_value;
        logic [63:0]  sess_value;
        logic         sess_given;
        logic [1:0]   missing;
    } manifest_result_t;

    localparam logic [63:0] VALUE_MAX = '1;

    string key_word [KeyCount] = '{{"snapshot", "_id"}, "sequence", "session"};

    manifest_result_t expected_q [$];

    logic [63:0] snap_store;
    logic [63:0] seq_store;
    logic [63:0] sess_store;
    logic [2:0]  seen_mask;
    logic [2:0]  key_match;
    logic [3:0]  key_len_seen;
    logic        after_equal;
    logic [63:0] val_acc;
    logic        val_has_digit;
    logic        val_bad;
    logic        line_has_bytes;
    logic        hold_cr;
    logic        bad_latched;
    int          errors = 0;
    int          results_seen = 0;

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
        results_checked = 0;
    end

    task automatic clear_line();
        key_match      = 3'b111;
        key_len_seen   = '0;
        after_equal    = 1'b0;
        val_acc        = '0;
        val_has_digit  = 1'b0;
        val_bad        = 1'b0;
        line_has_bytes = 1'b0;
    endtask

    task automatic clear_manifest();
        snap_store  = '0;
        seq_store   = '0;
        sess_store  = '0;
        seen_mask   = '0;
        hold_cr     = 1'b0;
        bad_latched = 1'b0;
        clear_line();
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [63:0] digit;
        line_has_bytes = 1'b1;
        if (after_equal) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                digit = 64'(c - CHAR_ZERO);
                if (val_acc > (VALUE_MAX - digit) / 10)
                    val_bad = 1'b1;
                else
                    val_acc = val_acc * 10 + digit;
                val_has_digit = 1'b1;
            end else begin
                val_bad = 1'b1;
            end
        end else if (c == CHAR_EQUAL) begin
            after_equal = 1'b1;
        end else begin
            for (int k = 0; k < KeyCount; k++) begin
                if (key_len_seen >= key_word[k].len() || key_word[k][key_len_seen] != c)
                    key_match[k] = 1'b0;
            end
            if (key_len_seen != 4'd15)
                key_len_seen = key_len_seen + 4'd1;
        end
    endtask

    task automatic close_line();
        int hit;
        hit = -1;
        if (!bad_latched && line_has_bytes) begin
            for (int k = 0; k < KeyCount; k++) begin
                if (key_match[k] && key_len_seen == key_word[k].len())
                    hit = k;
            end
            if (!after_equal || !val_has_digit || val_bad || hit < 0 || seen_mask[hit]) begin
                bad_latched = 1'b1;
            end else begin
                case (hit)
                    KEY_SNAPSHOT: snap_store = val_acc;
                    KEY_SEQUENCE: seq_store  = val_acc;
                    default:      sess_store = val_acc;
                endcase
                seen_mask[hit] = 1'b1;
            end
        end
        clear_line();
    endtask

    task automatic take_byte(input logic [7:0] c, input logic last);
        manifest_result_t res;
        if (!last) begin
            if (bad_latched)
                return;
            if (hold_cr) begin
                hold_cr = 1'b0;
                if (c == CHAR_LF) begin
                    close_line();
                    return;
                end
                absorb_char(CHAR_CR);
            end
            if (c == CHAR_CR)
                hold_cr = 1'b1;
            else if (c == CHAR_LF)
                close_line();
            else
                absorb_char(c);
        end else begin
            hold_cr = 1'b0;
            close_line();
            res = '0;
            if (bad_latched) begin
                res.status = STATUS_MALFORMED;
            end else if (seen_mask[1:0] != 2'b11) begin
                res.status  = STATUS_INCOMPLETE;
                res.missing = ~seen_mask[1:0];
            end else begin
                res.status     = STATUS_OK;
                res.snap_value = snap_store;
                res.seq_value  = seq_store;
                res.sess_value = sess_store;
                res.sess_given = seen_mask[KEY_SESSION];
            end
            expected_q.push_back(res);
            clear_manifest();
        end
    endtask

    task automatic check_result();
        manifest_result_t exp_r;
        results_seen++;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: status %0d data %h", m_tuser, m_tdata[194:0]);
            return;
        end
        exp_r = expected_q.pop_front();
        if (m_tuser !== exp_r.status || m_tdata[63:0] !== exp_r.snap_value
                || m_tdata[127:64] !== exp_r.seq_value || m_tdata[191:128] !== exp_r.sess_value
                || m_tdata[192] !== exp_r.sess_given || m_tdata[194:193] !== exp_r.missing) begin
            errors++;
            if (errors <= 10) begin
                $display("result %0d expected: status %0d snap %0d seq %0d sess %0d given %b miss %b",
                         results_seen, exp_r.status, exp_r.snap_value, exp_r.seq_value,
                         exp_r.sess_value, exp_r.sess_given, exp_r.missing);
                $display("result %0d actual:   status %0d snap %0d seq %0d sess %0d given %b miss %b",
                         results_seen, m_tuser, m_tdata[63:0], m_tdata[127:64],
                         m_tdata[191:128], m_tdata[192], m_tdata[194:193]);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_manifest();
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        mismatch_count  <= errors;
        pending_results <= expected_q.size();
        results_checked <= results_seen;
    end

endmodule

// File: verif/tb_key_value_manifest_parser_top.sv
`timescale 1ns / 100ps

module tb_key_value_manifest_parser_top;
    import kvmp_pkg::*;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;    // [7:0] data_byte
    logic         s_tlast  = 1'b0;  // end_of_input
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;          // [63:0] snapshot_value, [127:64] sequence_value,
                                    // [191:128] session_value, [192] session_given,
                                    // [194:193] missing_mask, [199:195] zero
    logic [1:0]   m_tuser;          // [1:0] status

    int mismatch_count;
    int pending_results;
    int results_checked;

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int bytes_sent     = 0;
    int manifests_sent = 0;

    byte unsigned manifest_text [$];
    string key_word [KeyCount] = '{{"snapshot", "_id"}, "sequence", "session"};

    key_value_manifest_parser_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    manifest_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            m_tready  <= 1'b0;
            hold_left <= 300;
            hold_ack  <= hold_req;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_manifest(input logic [7:0] last_data);
        foreach (manifest_text[i])
            send_byte(manifest_text[i], 1'b0);
        send_byte(last_data, 1'b1);
        manifests_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            manifest_text.push_back(s[i]);
    endtask

    task automatic add_end();
        if ($urandom_range(3) == 0)
            manifest_text.push_back(CHAR_CR);
        manifest_text.push_back(CHAR_LF);
    endtask

    function automatic string value_text();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: return $sformatf("%0d", $urandom_range(999));
            1: return $sformatf("%0d", v >> $urandom_range(63));
            2: return "18446744073709551615";
            3: return {"000", $sformatf("%0d", $urandom_range(99))};
            4: return "0";
            default: return $sformatf("%0d", v);
        endcase
    endfunction

    function automatic string overflow_text();
        case ($urandom_range(3))
            0: return "18446744073709551616";
            1: return {"18446744073709551615", $sformatf("%0d", $urandom_range(9))};
            2: return "99999999999999999999";
            default: return "100000000000000000000";
        endcase
    endfunction

    function automatic string bad_key(input int k);
        string s;
        s = key_word[k];
        case ($urandom_range(4))
            0: s.putc($urandom_range(s.len() - 1), 8'($urandom_range(8'h61, 8'h7A)));
            1: s = s.substr(0, s.len() - 2);
            2: s = {s, "x"};
            3: s = {s, "_extra_long"};
            default: begin
                s = "";
                repeat ($urandom_range(1, 20))
                    s = {s, string'(8'($urandom_range(8'h61, 8'h7A)))};
            end
        endcase
        return s;
    endfunction

    task automatic add_line(input int k, input int flaw);
        string val;
        int    at;
        val = value_text();
        at  = $urandom_range(val.len());
        case (flaw)
            1: add_text({bad_key(k), "=", val});
            2: add_text({key_word[k], val});
            3: add_text({key_word[k], "="});
            4: begin
                add_text({key_word[k], "="});
                for (int i = 0; i <= val.len(); i++) begin
                    if (i == at)
                        manifest_text.push_back(8'($urandom_range(8'h3A, 8'hFF)));
                    if (i < val.len())
                        manifest_text.push_back(val[i]);
                end
            end
            5: add_text({key_word[k], "=", val, "=", value_text()});
            6: add_text({key_word[k], "=", overflow_text()});
            7: begin
                add_text({key_word[k], "=", val});
                add_end();
                add_text({key_word[k], "=", value_text()});
            end
            8: begin
                at = $urandom_range(key_word[k].len());
                for (int i = 0; i <= key_word[k].len(); i++) begin
                    if (i == at)
                        manifest_text.push_back(8'h00);
                    if (i < key_word[k].len())
                        manifest_text.push_back(key_word[k][i]);
                end
                add_text({"=", val});
            end
            9: begin
                add_text({key_word[k], "=", val});
                manifest_text.push_back(CHAR_CR);
                add_text(value_text());
            end
            10: begin
                add_text({key_word[k], "=", val});
                manifest_text.push_back(CHAR_CR);
            end
            default: add_text({key_word[k], "=", val});
        endcase
    endtask

    task automatic build_manifest();
        int order [3];
        bit inc [3];
        int flaw;
        int flaw_pos;
        int last_pos;
        int j;
        int tmp;
        manifest_text.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 40)) begin
                case ($urandom_range(3))
                    0: manifest_text.push_back(CHAR_LF);
                    1: manifest_text.push_back(CHAR_EQUAL);
                    2: manifest_text.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
                    default: manifest_text.push_back(8'($urandom_range(255)));
                endcase
            end
            return;
        end
        order = '{KEY_SNAPSHOT, KEY_SEQUENCE, KEY_SESSION};
        for (int i = 2; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        inc[KEY_SNAPSHOT] = ($urandom_range(99) < 92);
        inc[KEY_SEQUENCE] = ($urandom_range(99) < 92);
        inc[KEY_SESSION]  = ($urandom_range(99) < 50);
        flaw     = ($urandom_range(99) < 30) ? $urandom_range(1, 10) : 0;
        flaw_pos = $urandom_range(2);
        if (flaw != 0)
            inc[order[flaw_pos]] = 1'b1;
        last_pos = -1;
        for (int p = 0; p < 3; p++)
            if (inc[order[p]])
                last_pos = p;
        for (int p = 0; p < 3; p++) begin
            if (!inc[order[p]])
                continue;
            if ($urandom_range(99) < 10)
                add_end();
            add_line(order[p], (p == flaw_pos) ? flaw : 0);
            if (p != last_pos) begin
                add_end();
            end else begin
                case ($urandom_range(3))
                    0: add_text("\n");
                    1: add_text("\r\n");
                    2: add_text("\r");
                    default: ;
                endcase
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        manifest_text.delete();
        send_manifest(8'hFF);
        add_text("\r");
        send_manifest(8'h00);
        manifest_text.delete();
        manifest_text = '{CHAR_LF, CHAR_CR, CHAR_LF, CHAR_EQUAL, 8'h00};
        send_manifest(8'h55);
        manifest_text.delete();
        add_text("session=0\r");
        send_manifest(8'hAA);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            int phase_start;
            int phase_count;
            phase_start = bytes_sent;
            phase_count = 0;
            tx_idle_pct <= (phase == 0) ? 15 : (phase == 1) ? 45 : 0;
            rx_idle_pct <= (phase == 0) ? 45 : (phase == 1) ? 15 : 0;
            while (bytes_sent - phase_start < 480 || phase_count < 16) begin
                if (phase == 0 && phase_count == 3) begin
                    hold_req <= hold_req + 1;
                    repeat (6) begin
                        manifest_text.delete();
                        if ($urandom_range(1) != 0)
                            add_text("sequence=7\n");
                        send_manifest(8'($urandom_range(255)));
                    end
                end
                build_manifest();
                send_manifest(8'($urandom_range(255)));
                phase_count++;
                if ($urandom_range(99) < 6)
                    drain_results();
            end
            drain_results();
        end

        repeat (12) @(posedge aclk);
        $display("Covered %0d byte transactions in %0d manifests, %0d results compared",
                 bytes_sent, manifests_sent, results_checked);
        $display("under three sender/receiver idle mixes and one long receiver hold");
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
